>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also checks through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/lwct_pkg.sv
// ----------------------------------------------------------------------------
// lwct_pkg
// Types and constants of the last writer conflict table.
// ----------------------------------------------------------------------------
`default_nettype none

package lwct_pkg;

  localparam int INDEX_BITS_DEF = 12;
  localparam int TAG_W          = 16;
  localparam int CODE_W         = 48;
  localparam int ADDR_W         = 48;
  localparam int ENTRY_W        = TAG_W + CODE_W;
  localparam int IN_DATA_W      = ADDR_W + TAG_W + CODE_W;
  localparam int OUT_DATA_W     = TAG_W + CODE_W;
  localparam int REQ_W          = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  localparam logic [CFG_IDX_W-1:0] CFG_READ_UPDATES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_WRITE = 1'b1;

  typedef struct packed {
    logic read_updates_entry;
    logic detect_on_write;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/last_writer_conflict_table.sv
// ----------------------------------------------------------------------------
// last_writer_conflict_table
// Direct-mapped last-accessor table that flags cross-thread accesses.
// ----------------------------------------------------------------------------
// After reset the table is zeroed one entry per cycle, all 2**INDEX_BITS
// entries (4096 at the default), with s_tready low; configuration writes are
// taken throughout. Then items are accepted one at a time: the table RAM has
// a registered read, and the next lookup waits until the current one has left
// the lookup stage, held there while a full output register is not taken;
// its result then waits in that register, on m_tvalid, and the next item
// is taken meanwhile. Reads, writes and queries all return the prior tag
// and code address of the entry selected by the low INDEX_BITS address bits.
`default_nettype none

module last_writer_conflict_table #(
  parameter int INDEX_BITS = lwct_pkg::INDEX_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lwct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lwct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // address [47:0], thread_tag [63:48], code_address [111:64]
  input  wire logic [lwct_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type [1:0]
  input  wire logic [lwct_pkg::REQ_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // prior_thread [15:0], prior_code_address [63:16]
  output logic      [lwct_pkg::OUT_DATA_W-1:0] m_tdata,
  // conflict [0]
  output logic                                 m_tuser
);
  import lwct_pkg::*;

  cfg_t                  cfg;
  logic                  table_busy;
  logic                  rd_en;
  logic [INDEX_BITS-1:0] rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [ENTRY_W-1:0]    wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_updates_entry <= 1'b0;
      cfg.detect_on_write    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READ_UPDATES: cfg.read_updates_entry <= cfg_data[0];
        CFG_DETECT_WRITE: cfg.detect_on_write    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lwct_table #(
    .INDEX_BITS (INDEX_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (table_busy)
  );

  lwct_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .table_busy (table_busy),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/lwct_table.sv
// ----------------------------------------------------------------------------
// lwct_table
// Accessor table RAM with registered read and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lwct_table #(
  parameter int INDEX_BITS = lwct_pkg::INDEX_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_en,
  input  wire logic [INDEX_BITS-1:0]        rd_addr,
  output logic      [lwct_pkg::ENTRY_W-1:0] rd_data,
  input  wire logic                         wr_en,
  input  wire logic [INDEX_BITS-1:0]        wr_addr,
  input  wire logic [lwct_pkg::ENTRY_W-1:0] wr_data,
  output logic                              busy
);
  import lwct_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;

  logic [ENTRY_W-1:0]    mem [DEPTH];
  logic                  clr_active;
  logic [INDEX_BITS-1:0] clr_idx;

  assign busy = clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == INDEX_BITS'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lwct_core.sv
// ----------------------------------------------------------------------------
// lwct_core
// Lookup stage, tag compare, write-back and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lwct_core #(
  parameter int INDEX_BITS = lwct_pkg::INDEX_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lwct_pkg::cfg_t                  cfg,
  input  wire logic                            table_busy,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [lwct_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [lwct_pkg::REQ_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [lwct_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                                 m_tuser,
  output logic                                 rd_en,
  output logic      [INDEX_BITS-1:0]           rd_addr,
  input  wire logic [lwct_pkg::ENTRY_W-1:0]    rd_data,
  output logic                                 wr_en,
  output logic      [INDEX_BITS-1:0]           wr_addr,
  output logic      [lwct_pkg::ENTRY_W-1:0]    wr_data
);
  import lwct_pkg::*;

  logic                  s1_valid;
  logic [REQ_W-1:0]      s1_req;
  logic [INDEX_BITS-1:0] s1_slot;
  logic [TAG_W-1:0]      s1_tag;
  logic [CODE_W-1:0]     s1_code;

  logic                  advance;
  logic [TAG_W-1:0]      old_tag;
  logic [CODE_W-1:0]     old_code;
  logic                  differs;
  logic                  conflict_next;

  // one item in the lookup stage at a time, so a read never races a write
  assign s_tready = !table_busy && !s1_valid;
  assign rd_en    = s_tvalid && s_tready;
  assign rd_addr  = s_tdata[INDEX_BITS-1:0];

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign old_tag  = rd_data[ENTRY_W-1:CODE_W];
  assign old_code = rd_data[CODE_W-1:0];
  assign differs  = (old_tag != s1_tag);
  assign wr_addr  = s1_slot;
  assign wr_data  = {s1_tag, s1_code};

  always_comb begin
    conflict_next = 1'b0;
    wr_en         = 1'b0;
    case (req_e'(s1_req))
      REQ_READ: begin
        conflict_next = differs;
        wr_en         = advance && cfg.read_updates_entry;
      end
      REQ_WRITE: begin
        conflict_next = differs && cfg.detect_on_write;
        wr_en         = advance;
      end
      default: begin
        conflict_next = 1'b0;
        wr_en         = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_req  <= s_tuser;
      s1_slot <= s_tdata[INDEX_BITS-1:0];
      s1_tag  <= s_tdata[ADDR_W +: TAG_W];
      s1_code <= s_tdata[ADDR_W + TAG_W +: CODE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {old_code, old_tag};
      m_tuser <= conflict_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lwct_checker.sv
// ----------------------------------------------------------------------------
// lwct_checker
// Port-level checks of the last writer conflict table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lwct_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [lwct_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                            m_tuser
);

  // the zeroing sweep holds off items right after reset
  `ASSERT_NEXT_ALWAYS(a_no_accept_after_rst, clk, rst, !s_tready)
  `ASSERT_NEXT_ALWAYS(a_no_result_after_rst, clk, rst, !m_tvalid)
  // the lookup interlock blocks the cycle after an accepted item
  `ASSERT_NEXT(a_interlock, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
               m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind last_writer_conflict_table lwct_checker u_lwct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
